// ===== rtl/tps_pkg.sv =====
// Shared widths, types and helpers for the triangle plane slice pipeline.
package tps_pkg;

    localparam int CW        = 32;             // coordinate width
    localparam int DW        = CW + 1;         // width of a coordinate difference
    localparam int PW        = 2 * DW;         // product of two differences
    localparam int NW        = PW + 1;         // normal component
    localparam int TOL_W     = 16;             // tolerance register width
    localparam int LERP_LAT  = DW + 3;         // prep, multiply, DW divide steps, round
    localparam int NORM_LAT  = 3;              // differences, products, subtract
    localparam int ORI_LAT   = 3;              // select, partial products, sums
    localparam int PIPE_D    = 1 + LERP_LAT + ORI_LAT;
    localparam int HI_W      = NW - CW;        // upper slice of a normal component
    localparam int HP_W      = HI_W + DW;      // upper partial product
    localparam int LP_W      = 2 * DW;         // lower partial product
    localparam int DOTW      = CW + HP_W + 1;  // orientation dot product
    localparam int IN_W      = 10 * CW;
    localparam int OUT_W     = 4 * CW;
    localparam int ADDR_W    = 3;
    localparam int APB_W     = 32;

    // register index carried in paddr[2]
    localparam logic REG_EQ_TOL = 1'b0;
    localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(1);

    typedef struct packed {
        logic [CW-1:0] x;
        logic [CW-1:0] y;
        logic [CW-1:0] z;
    } tps_vtx_t;

    // control and fixed endpoints that ride alongside the dividers
    typedef struct packed {
        logic          hit;
        logic          use_div;   // at least one endpoint comes from interpolation
        logic          vp_sel;    // start is a vertex on the plane, end is one crossing
        logic [CW-1:0] ax;
        logic [CW-1:0] ay;
        logic [CW-1:0] bx;
        logic [CW-1:0] by;
    } tps_side_t;

    typedef struct packed {
        tps_side_t     side;
        tps_vtx_t      vr;
        tps_vtx_t      vo1;
        tps_vtx_t      vo2;
        tps_vtx_t      v0;
        tps_vtx_t      v1;
        tps_vtx_t      v2;
        logic [CW-1:0] zc;
    } tps_cls_t;

    function automatic logic [DW-1:0] absd(input logic [CW-1:0] a, input logic [CW-1:0] b);
        logic signed [DW-1:0] d;
        begin
            d = $signed({a[CW-1], a}) - $signed({b[CW-1], b});
            return d[DW-1] ? DW'(-d) : DW'(d);
        end
    endfunction

endpackage

// ===== rtl/tps_classify.sv =====
// Height compares, case decode and operand selection; first pipeline stage.
module tps_classify import tps_pkg::*; (
    input  logic             aclk,
    input  logic             en,
    input  logic [IN_W-1:0]  tdata,
    input  logic [TOL_W-1:0] tol,
    output tps_cls_t         cls
);

    tps_vtx_t      v [3];
    logic [CW-1:0] zc;
    logic [2:0]    gt, lt, eq;
    tps_cls_t      cls_next;
    tps_cls_t      cls_reg;

    function automatic tps_vtx_t pick(input logic [1:0] s, input tps_vtx_t a,
                                      input tps_vtx_t b, input tps_vtx_t c);
        case (s)
            2'd0:    return a;
            2'd1:    return b;
            default: return c;
        endcase
    endfunction

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            v[i].x = tdata[(3*i)*CW +: CW];
            v[i].y = tdata[(3*i+1)*CW +: CW];
            v[i].z = tdata[(3*i+2)*CW +: CW];
        end
        zc = tdata[9*CW +: CW];
        for (int i = 0; i < 3; i++) begin
            gt[i] = $signed(zc) < $signed(v[i].z);
            lt[i] = $signed(v[i].z) < $signed(zc);
            eq[i] = absd(v[i].z, zc) < DW'(tol);
        end
    end

    always_comb begin
        logic       hitf, vpv, xing;
        logic [1:0] fa, fb, vp, r, o1, o2;
        logic       s01, s02, s12;
        tps_vtx_t   pa, pb;
        hitf  = 1'b0;
        vpv   = 1'b0;
        xing  = 1'b0;
        fa = 2'd0; fb = 2'd0; vp = 2'd0; r = 2'd0; o1 = 2'd0; o2 = 2'd0;
        s01 = (gt[0] && gt[1]) || (lt[0] && lt[1]);
        s02 = (gt[0] && gt[2]) || (lt[0] && lt[2]);
        s12 = (gt[1] && gt[2]) || (lt[1] && lt[2]);
        if ((&gt) || (&lt)) begin
            hitf = 1'b0;
        end else if (eq[0]) begin
            if (eq[1]) begin
                if (!eq[2]) begin
                    hitf = 1'b1; fa = 2'd0; fb = 2'd1;
                end
            end else if (eq[2]) begin
                hitf = 1'b1; fa = 2'd0; fb = 2'd2;
            end else if (!s12) begin
                vpv = 1'b1; vp = 2'd0; r = 2'd1; o1 = 2'd2;
            end
        end else if (eq[1]) begin
            if (eq[2]) begin
                hitf = 1'b1; fa = 2'd1; fb = 2'd2;
            end else if (!s02) begin
                vpv = 1'b1; vp = 2'd1; r = 2'd0; o1 = 2'd2;
            end
        end else if (eq[2]) begin
            if (!s01) begin
                vpv = 1'b1; vp = 2'd2; r = 2'd0; o1 = 2'd1;
            end
        end else if (s01) begin
            xing = 1'b1; r = 2'd2; o1 = 2'd0; o2 = 2'd1;
        end else if (s02) begin
            xing = 1'b1; r = 2'd1; o1 = 2'd0; o2 = 2'd2;
        end else if (s12) begin
            xing = 1'b1; r = 2'd0; o1 = 2'd1; o2 = 2'd2;
        end

        pa = pick(hitf ? fa : vp, v[0], v[1], v[2]);
        pb = pick(fb, v[0], v[1], v[2]);

        cls_next.side.hit     = hitf | vpv | xing;
        cls_next.side.use_div = vpv | xing;
        cls_next.side.vp_sel  = vpv;
        cls_next.side.ax      = (hitf || vpv) ? pa.x : '0;
        cls_next.side.ay      = (hitf || vpv) ? pa.y : '0;
        cls_next.side.bx      = hitf ? pb.x : '0;
        cls_next.side.by      = hitf ? pb.y : '0;
        cls_next.vr           = pick(r, v[0], v[1], v[2]);
        cls_next.vo1          = pick(o1, v[0], v[1], v[2]);
        cls_next.vo2          = pick(o2, v[0], v[1], v[2]);
        cls_next.v0           = v[0];
        cls_next.v1           = v[1];
        cls_next.v2           = v[2];
        cls_next.zc           = zc;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cls_reg <= cls_next;
        end
    end

    assign cls = cls_reg;

endmodule

// ===== rtl/tps_lerp.sv =====
// One interpolated coordinate: multiply, then a restoring divider one bit per stage.
module tps_lerp import tps_pkg::*; (
    input  logic          aclk,
    input  logic          en,
    input  logic [CW-1:0] xr,
    input  logic [CW-1:0] xo,
    input  logic [CW-1:0] zr,
    input  logic [CW-1:0] zo,
    input  logic [CW-1:0] zc,
    output logic [CW-1:0] res
);

    logic [DW-1:0] num_p_reg, den_p_reg, dx_p_reg;
    logic          neg_p_reg;
    logic [CW-1:0] xr_p_reg;

    logic [DW-1:0] rem_reg [0:DW];
    logic [DW-1:0] lo_reg  [0:DW-1];
    logic [DW-1:0] q_reg   [0:DW];
    logic [DW-1:0] den_reg [0:DW];
    logic          neg_reg [0:DW];
    logic [CW-1:0] xr_reg  [0:DW];

    logic [DW-1:0] rem_next [1:DW];
    logic [DW-1:0] q_next   [1:DW];
    logic [PW-1:0] prod;
    logic [CW-1:0] res_reg;
    logic [CW-1:0] res_next;

    assign prod = num_p_reg * dx_p_reg;

    always_comb begin
        for (int s = 0; s < DW; s++) begin
            logic [DW:0] t;
            logic        ge;
            t  = {rem_reg[s], lo_reg[s][DW-1]};
            ge = t >= {1'b0, den_reg[s]};
            rem_next[s+1] = ge ? DW'(t - {1'b0, den_reg[s]}) : t[DW-1:0];
            q_next[s+1]   = {q_reg[s][DW-2:0], ge};
        end
    end

    // round to nearest, ties away from zero, then apply the sign
    always_comb begin
        logic [DW-1:0] rem, den, qf;
        logic [DW-1:0] xe;
        rem = rem_reg[DW];
        den = den_reg[DW];
        qf  = q_reg[DW] + DW'(rem >= DW'(den - rem));
        xe  = {xr_reg[DW][CW-1], xr_reg[DW]};
        if (den == '0) begin
            res_next = xr_reg[DW];
        end else begin
            res_next = neg_reg[DW] ? CW'(xe - qf) : CW'(xe + qf);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            num_p_reg <= absd(zc, zr);
            den_p_reg <= absd(zo, zr);
            dx_p_reg  <= absd(xo, xr);
            neg_p_reg <= ($signed(zc) < $signed(zr)) ^ ($signed(zo) < $signed(zr))
                         ^ ($signed(xo) < $signed(xr));
            xr_p_reg  <= xr;

            rem_reg[0] <= prod[PW-1:DW];
            lo_reg[0]  <= prod[DW-1:0];
            q_reg[0]   <= '0;
            den_reg[0] <= den_p_reg;
            neg_reg[0] <= neg_p_reg;
            xr_reg[0]  <= xr_p_reg;

            for (int s = 0; s < DW; s++) begin
                rem_reg[s+1] <= rem_next[s+1];
                q_reg[s+1]   <= q_next[s+1];
                den_reg[s+1] <= den_reg[s];
                neg_reg[s+1] <= neg_reg[s];
                xr_reg[s+1]  <= xr_reg[s];
            end
            for (int s = 0; s < DW - 1; s++) begin
                lo_reg[s+1]  <= {lo_reg[s][DW-2:0], 1'b0};
            end

            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

// ===== rtl/tps_normal.sv =====
// X and Y components of the face normal (v1-v0)x(v2-v0), three stages.
module tps_normal import tps_pkg::*; (
    input  logic                 aclk,
    input  logic                 en,
    input  tps_vtx_t             v0,
    input  tps_vtx_t             v1,
    input  tps_vtx_t             v2,
    output logic signed [NW-1:0] nx,
    output logic signed [NW-1:0] ny
);

    logic signed [DW-1:0] ex_reg, ey_reg, ez_reg, fx_reg, fy_reg, fz_reg;
    logic signed [PW-1:0] p1_reg, p2_reg, p3_reg, p4_reg;
    logic signed [NW-1:0] nx_reg, ny_reg;

    function automatic logic signed [DW-1:0] dif(input logic [CW-1:0] a,
                                                 input logic [CW-1:0] b);
        return $signed({a[CW-1], a}) - $signed({b[CW-1], b});
    endfunction

    always_ff @(posedge aclk) begin
        if (en) begin
            ex_reg <= dif(v1.x, v0.x);
            ey_reg <= dif(v1.y, v0.y);
            ez_reg <= dif(v1.z, v0.z);
            fx_reg <= dif(v2.x, v0.x);
            fy_reg <= dif(v2.y, v0.y);
            fz_reg <= dif(v2.z, v0.z);
            p1_reg <= ey_reg * fz_reg;
            p2_reg <= ez_reg * fy_reg;
            p3_reg <= ez_reg * fx_reg;
            p4_reg <= ex_reg * fz_reg;
            nx_reg <= NW'(p1_reg) - NW'(p2_reg);
            ny_reg <= NW'(p3_reg) - NW'(p4_reg);
        end
    end

    assign nx = nx_reg;
    assign ny = ny_reg;

endmodule

// ===== rtl/tps_orient.sv =====
// Endpoint select and segment orientation against (n.y, -n.x); three stages.
module tps_orient import tps_pkg::*; (
    input  logic                 aclk,
    input  logic                 en,
    input  tps_side_t            side,
    input  logic [CW-1:0]        la_x,
    input  logic [CW-1:0]        la_y,
    input  logic [CW-1:0]        lb_x,
    input  logic [CW-1:0]        lb_y,
    input  logic signed [NW-1:0] nx,
    input  logic signed [NW-1:0] ny,
    output logic                 hit,
    output logic [OUT_W-1:0]     seg
);

    logic [CW-1:0]          ax, ay, bx, by;
    logic                   hit1_reg, hit2_reg, hit3_reg;
    logic [4*CW-1:0]        pts1_reg, pts2_reg, pts3_reg;
    logic signed [DW-1:0]   sdx1_reg, sdy1_reg;
    logic signed [NW-1:0]   nx1_reg, ny1_reg;
    logic signed [HP_W-1:0] pyh_reg, pxh_reg;
    logic signed [LP_W-1:0] pyl_reg, pxl_reg;
    logic signed [DOTW-1:0] dpos_reg, dneg_reg;

    always_comb begin
        if (!side.use_div) begin
            ax = side.ax; ay = side.ay; bx = side.bx; by = side.by;
        end else if (side.vp_sel) begin
            ax = side.ax; ay = side.ay; bx = la_x; by = la_y;
        end else begin
            ax = la_x; ay = la_y; bx = lb_x; by = lb_y;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            hit1_reg <= side.hit;
            pts1_reg <= {by, bx, ay, ax};
            sdx1_reg <= $signed({bx[CW-1], bx}) - $signed({ax[CW-1], ax});
            sdy1_reg <= $signed({by[CW-1], by}) - $signed({ay[CW-1], ay});
            nx1_reg  <= nx;
            ny1_reg  <= ny;

            hit2_reg <= hit1_reg;
            pts2_reg <= pts1_reg;
            pyh_reg  <= $signed(ny1_reg[NW-1:CW]) * sdx1_reg;
            pyl_reg  <= $signed({1'b0, ny1_reg[CW-1:0]}) * sdx1_reg;
            pxh_reg  <= $signed(nx1_reg[NW-1:CW]) * sdy1_reg;
            pxl_reg  <= $signed({1'b0, nx1_reg[CW-1:0]}) * sdy1_reg;

            hit3_reg <= hit2_reg;
            pts3_reg <= pts2_reg;
            dpos_reg <= (DOTW'(pyh_reg) <<< CW) + DOTW'(pyl_reg);
            dneg_reg <= (DOTW'(pxh_reg) <<< CW) + DOTW'(pxl_reg);
        end
    end

    // a negative dot product swaps start and end
    always_comb begin
        hit = hit3_reg;
        if (dpos_reg < dneg_reg) begin
            seg = {pts3_reg[2*CW-1:0], pts3_reg[4*CW-1:2*CW]};
        end else begin
            seg = pts3_reg;
        end
    end

endmodule

// ===== rtl/triangle_plane_slice_core.sv =====
// Top level of the triangle plane slice pipeline.
//
// Streaming core that cuts one triangle per transaction with the plane z = slice_z
// and returns the XY segment of the cut.
// Input channel (s_): tdata carries the three vertices and the slice height, all
// signed Q16.16. Output channel (m_): tdata carries the segment endpoints, tuser
// carries hit; a miss returns hit clear and all-zero endpoints.
// The APB port holds eq_tolerance at byte address 0; write it only while idle.
// Pipeline: the compares and case decode are registered when a transaction is
// accepted, then 36 stages for each interpolation unit (prep, multiply, a 33-stage
// restoring divider that resolves one quotient bit per stage, round), three for
// the orientation products, and the output register.
// Throughput: one transaction per cycle while m_tready stays high.
// Stall: the whole pipeline holds while the output register is full and not
// taken; s_tready drops in that cycle, so nothing is lost or repeated.
// Reset (aresetn low, synchronous): clear all valid bits, empty the output and
// restore eq_tolerance to 1. Payload registers are not reset.
module triangle_plane_slice_core import tps_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    // APB configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [APB_W-1:0]  pwdata,
    output logic [APB_W-1:0]  prdata,
    output logic              pready,
    // input stream
    input  logic              s_tvalid,
    output logic              s_tready,
    // fields from bit 0 up: vertex0_x, vertex0_y, vertex0_z, vertex1_x, vertex1_y,
    // vertex1_z, vertex2_x, vertex2_y, vertex2_z, slice_z
    input  logic [IN_W-1:0]   s_tdata,
    // result stream
    output logic              m_tvalid,
    input  logic              m_tready,
    // fields from bit 0 up: start_x, start_y, end_x, end_y
    output logic [OUT_W-1:0]  m_tdata,
    // fields from bit 0 up: hit
    output logic              m_tuser
);

    logic [TOL_W-1:0] tol_reg, tol_next;
    logic             en;
    logic             vld_reg [0:PIPE_D-1];
    tps_cls_t         cls;
    tps_side_t        side_reg [0:LERP_LAT-1];
    logic signed [NW-1:0] nx, ny;
    logic signed [NW-1:0] nx_dly_reg [0:LERP_LAT-NORM_LAT-1];
    logic signed [NW-1:0] ny_dly_reg [0:LERP_LAT-NORM_LAT-1];
    logic [CW-1:0]    la_x, la_y, lb_x, lb_y;
    logic             ori_hit;
    logic [OUT_W-1:0] ori_seg;
    logic             m_tvalid_reg, m_tvalid_next;
    logic [OUT_W-1:0] m_tdata_reg;
    logic             m_tuser_reg;

    // advance everything unless a finished result is waiting and not taken
    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;

    // ---------------- configuration ----------------
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_EQ_TOL) ? APB_W'(tol_reg) : '0;

    always_comb begin
        tol_next = tol_reg;
        if (psel && penable && pwrite && pready && paddr[2] == REG_EQ_TOL) begin
            tol_next = pwdata[TOL_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tol_reg <= TOL_RESET;
        end else begin
            tol_reg <= tol_next;
        end
    end

    // ---------------- datapath ----------------
    tps_classify u_cls (
        .aclk  (aclk),
        .en    (en),
        .tdata (s_tdata),
        .tol   (tol_reg),
        .cls   (cls)
    );

    tps_lerp u_lerp_ax (.aclk(aclk), .en(en), .xr(cls.vr.x), .xo(cls.vo1.x),
                        .zr(cls.vr.z), .zo(cls.vo1.z), .zc(cls.zc), .res(la_x));
    tps_lerp u_lerp_ay (.aclk(aclk), .en(en), .xr(cls.vr.y), .xo(cls.vo1.y),
                        .zr(cls.vr.z), .zo(cls.vo1.z), .zc(cls.zc), .res(la_y));
    tps_lerp u_lerp_bx (.aclk(aclk), .en(en), .xr(cls.vr.x), .xo(cls.vo2.x),
                        .zr(cls.vr.z), .zo(cls.vo2.z), .zc(cls.zc), .res(lb_x));
    tps_lerp u_lerp_by (.aclk(aclk), .en(en), .xr(cls.vr.y), .xo(cls.vo2.y),
                        .zr(cls.vr.z), .zo(cls.vo2.z), .zc(cls.zc), .res(lb_y));

    tps_normal u_nrm (
        .aclk (aclk),
        .en   (en),
        .v0   (cls.v0),
        .v1   (cls.v1),
        .v2   (cls.v2),
        .nx   (nx),
        .ny   (ny)
    );

    // hold side info and the normal until the interpolated points arrive
    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[0] <= cls.side;
            for (int i = 1; i < LERP_LAT; i++) begin
                side_reg[i] <= side_reg[i-1];
            end
            nx_dly_reg[0] <= nx;
            ny_dly_reg[0] <= ny;
            for (int i = 1; i < LERP_LAT - NORM_LAT; i++) begin
                nx_dly_reg[i] <= nx_dly_reg[i-1];
                ny_dly_reg[i] <= ny_dly_reg[i-1];
            end
        end
    end

    tps_orient u_ori (
        .aclk (aclk),
        .en   (en),
        .side (side_reg[LERP_LAT-1]),
        .la_x (la_x),
        .la_y (la_y),
        .lb_x (lb_x),
        .lb_y (lb_y),
        .nx   (nx_dly_reg[LERP_LAT-NORM_LAT-1]),
        .ny   (ny_dly_reg[LERP_LAT-NORM_LAT-1]),
        .hit  (ori_hit),
        .seg  (ori_seg)
    );

    // ---------------- valid chain and output register ----------------
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (en) begin
            m_tvalid_next = vld_reg[PIPE_D-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < PIPE_D; i++) begin
                vld_reg[i] <= 1'b0;
            end
            m_tvalid_reg <= 1'b0;
        end else begin
            if (en) begin
                vld_reg[0] <= s_tvalid;
                for (int i = 1; i < PIPE_D; i++) begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_tdata_reg <= ori_seg;
            m_tuser_reg <= ori_hit;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// ===== rtl/tps_checker.sv =====
// Port-level checks for the slice core, bound to the top level.
module tps_checker import tps_pkg::*; (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_tready,
    input logic              m_tvalid,
    input logic              m_tready,
    input logic [OUT_W-1:0]  m_tdata,
    input logic              m_tuser
);

    // a held result keeps its payload
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // a miss carries zero endpoints
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata == '0)
        else $error("miss with nonzero endpoints");

    // the input side stalls whenever the output is blocked
    a_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input accepted while output blocked");

    // reset empties the output
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind triangle_plane_slice_core tps_checker u_tps_checker (.*);
